/* rtl/core/char_lcd_nibble_interface_assert.svh */
// assertion macros for the character lcd nibble interface checker
// expects clk and arst_n in the scope where the macros are used
`ifndef CHAR_LCD_NIBBLE_INTERFACE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_ASSERT_SVH

// same-cycle implication
`define CLNI_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("char lcd nibble interface: assertion failed");

// next-cycle implication
`define CLNI_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("char lcd nibble interface: assertion failed");

`endif

/* rtl/core/clni_pkg.sv */
// shared types and constants for the character lcd nibble interface
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package clni_pkg;

	localparam int HOLD_W          = 24;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 24'd32000;
	localparam int INIT_LENGTH_DEF = 6;
	localparam int INIT_TABLE_SIZE = 6;
	localparam int IDX_W           = $clog2(INIT_TABLE_SIZE + 1);

	localparam logic [1:0] KIND_COMMAND = 2'd0;
	localparam logic [1:0] KIND_DATA    = 2'd1;
	localparam logic [1:0] KIND_CURSOR  = 2'd2;
	localparam logic [1:0] KIND_INIT    = 2'd3;

	localparam logic [7:0] CURSOR_BASE = 8'h80;
	localparam logic [7:0] ROW_OFFSET  = 8'h40;

	localparam logic [1:0] HOLD_ONE = 2'd1;
	localparam logic [1:0] HOLD_TWO = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       row;
	} req_item_t;

	typedef struct packed {
		logic [3:0] data_nibble;
		logic       reg_select;
		logic       enable_pin;
		logic [1:0] hold_periods;
		logic       last;
	} pin_item_t;

	function automatic logic [7:0] init_cmd(input logic [IDX_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h01;
			3'd1: c = 8'h02;
			3'd2: c = 8'h28;
			3'd3: c = 8'h06;
			3'd4: c = 8'h0F;
			3'd5: c = 8'h80;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/char_lcd_nibble_interface.sv */
// character lcd nibble interface: microcoded sequencer, one pin state per item
// an accepted request loads the sequencer, which then registers its pin states one by one
// a byte gives 4 pin states, init a zero one then each table byte; busy blocks new requests
// the step counter walks the control rom one step a cycle, stalling on the output register
// reset: asynchronous, clears the sequencer and output valid; hold period resets to 32000
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_interface #(
	parameter int INIT_LENGTH = clni_pkg::INIT_LENGTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cmd_valid,
	output logic                          cmd_stall,
	input  clni_pkg::req_item_t           cmd,
	output logic                          pin_valid,
	input  wire                           pin_stall,
	output clni_pkg::pin_item_t           pin_state,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [clni_pkg::HOLD_W-1:0]    cfg_data
);
	import clni_pkg::*;

	localparam logic [IDX_W-1:0] INIT_COUNT =
		IDX_W'((INIT_LENGTH > INIT_TABLE_SIZE) ? INIT_TABLE_SIZE : INIT_LENGTH);

	typedef enum logic [1:0] {NIB_HI, NIB_LO, NIB_ZERO} nib_sel_t;
	typedef enum logic [1:0] {BR_NEXT, BR_ALWAYS, BR_MORE} br_op_t;

	localparam logic [2:0] PC_HI_EN = 3'd0;
	localparam logic [2:0] PC_IDLE  = 3'd4;
	localparam logic [2:0] PC_LOAD  = 3'd5;

	typedef struct packed {
		logic       emit;
		nib_sel_t   nib;
		logic       en;
		logic       byte_end;
		logic       load;
		br_op_t     br;
		logic [2:0] target;
	} ctrl_word_t;

	function automatic ctrl_word_t ucode(input logic [2:0] pc);
		ctrl_word_t w;
		w = '{emit: 1'b0, nib: NIB_ZERO, en: 1'b0, byte_end: 1'b0, load: 1'b0,
			br: BR_MORE, target: PC_LOAD};
		case (pc)
			3'd0: begin
				w.emit = 1'b1; w.nib = NIB_HI; w.en = 1'b1; w.br = BR_NEXT;
			end
			3'd1: begin
				w.emit = 1'b1; w.nib = NIB_HI; w.br = BR_NEXT;
			end
			3'd2: begin
				w.emit = 1'b1; w.nib = NIB_LO; w.en = 1'b1; w.br = BR_NEXT;
			end
			3'd3: begin
				w.emit = 1'b1; w.nib = NIB_LO; w.byte_end = 1'b1;
				w.br = BR_MORE; w.target = PC_LOAD;
			end
			3'd4: begin
				w.emit = 1'b1; w.br = BR_ALWAYS; w.target = PC_LOAD;
			end
			3'd5: begin
				w.load = 1'b1; w.br = BR_ALWAYS; w.target = PC_HI_EN;
			end
			default: begin
				w.br = BR_MORE; w.target = PC_LOAD;
			end
		endcase
		return w;
	endfunction

	logic [HOLD_W-1:0] hold_period_cycles_q;
	logic              busy_q;
	logic [2:0]        pc_q;
	logic [IDX_W-1:0]  idx_q;
	logic              init_q;
	logic              rs_q;
	logic [7:0]        byte_q;
	logic              pin_valid_q;
	pin_item_t         pin_q;

	ctrl_word_t cw;
	logic       out_free;
	logic       more;
	logic       fire;
	logic       accept;
	logic [3:0] nib;
	logic [7:0] cursor_cmd;

	always_comb begin
		cw       = ucode(pc_q);
		out_free = !pin_valid_q || !pin_stall;
		more     = init_q && (idx_q < INIT_COUNT);
		fire     = busy_q && (!cw.emit || out_free);
		accept   = cmd_valid && !busy_q;
		case (cw.nib)
			NIB_HI:  nib = byte_q[7:4];
			NIB_LO:  nib = byte_q[3:0];
			default: nib = 4'd0;
		endcase
		cursor_cmd = CURSOR_BASE | (cmd.row ? ROW_OFFSET : 8'h00) | {2'b00, cmd.value[5:0]};
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q               <= 1'b0;
			pc_q                 <= PC_HI_EN;
			idx_q                <= '0;
			pin_valid_q          <= 1'b0;
			hold_period_cycles_q <= HOLD_RESET;
		end else begin
			if (cfg_valid) begin
				hold_period_cycles_q <= cfg_data;
			end
			if (fire && cw.emit) begin
				pin_valid_q <= 1'b1;
			end else if (!pin_stall) begin
				pin_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				pc_q   <= (cmd.kind == KIND_INIT) ? PC_IDLE : PC_HI_EN;
			end else if (fire) begin
				if (cw.load) begin
					idx_q <= idx_q + 1'b1;
				end
				case (cw.br)
					BR_NEXT: pc_q <= pc_q + 3'd1;
					BR_ALWAYS: pc_q <= cw.target;
					default: begin
						if (more) begin
							pc_q <= cw.target;
						end else begin
							busy_q <= 1'b0;
						end
					end
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			init_q <= (cmd.kind == KIND_INIT);
			rs_q   <= (cmd.kind == KIND_DATA);
			byte_q <= (cmd.kind == KIND_CURSOR) ? cursor_cmd : cmd.value;
		end else if (fire && cw.load) begin
			rs_q   <= 1'b0;
			byte_q <= init_cmd(idx_q);
		end
		if (fire && cw.emit) begin
			pin_q.data_nibble  <= nib;
			pin_q.reg_select   <= (cw.nib == NIB_ZERO) ? 1'b0 : rs_q;
			pin_q.enable_pin   <= cw.en;
			pin_q.hold_periods <= (cw.byte_end && rs_q) ? HOLD_TWO : HOLD_ONE;
			pin_q.last         <= cw.byte_end && !more;
		end
	end

	assign cmd_stall = busy_q;
	assign pin_valid = pin_valid_q;
	assign pin_state = pin_q;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* rtl/core/clni_checker.sv */
// port-level checker for the character lcd nibble interface, bound to the top level
// depends on clni_pkg and char_lcd_nibble_interface_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_nibble_interface_assert.svh"

module clni_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 cmd_valid,
	input wire                 cmd_stall,
	input wire                 pin_valid,
	input wire                 pin_stall,
	input clni_pkg::pin_item_t pin_state
);
	import clni_pkg::*;

	logic held;
	logic cmd_taken;
	logic strobe;
	logic long_hold;
	logic fin;

	assign held      = pin_valid && pin_stall;
	assign cmd_taken = cmd_valid && !cmd_stall;
	assign strobe    = pin_valid && pin_state.enable_pin;
	assign long_hold = pin_valid && (pin_state.hold_periods == HOLD_TWO);
	assign fin       = pin_valid && pin_state.last;

	`CLNI_ASSERT_NEXT(a_pin_hold, held, pin_valid && $stable(pin_state))
	`CLNI_ASSERT_NOW(a_strobe_short, strobe, pin_state.hold_periods == HOLD_ONE)
	`CLNI_ASSERT_NOW(a_long_hold_data, long_hold, pin_state.reg_select && pin_state.last)
	`CLNI_ASSERT_NOW(a_last_low, fin, !pin_state.enable_pin)
	`CLNI_ASSERT_NEXT(a_busy_after_take, cmd_taken, cmd_stall)

endmodule

bind char_lcd_nibble_interface clni_checker u_clni_checker (.*);

`default_nettype wire
